// ===== sv/assert_macros.svh =====
// Assertion macros used by the formatter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HOFF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("formatter assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define HOFF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("formatter assertion failed");

`endif

// ===== sv/hoff_pkg.sv =====
// Constants, codes and the digit lookup of the hex/octal field formatter.
package hoff_pkg;

    localparam int MAX_WIDTH_DEF = 64;

    localparam int VALUE_W  = 64;
    localparam int FWIDTH_W = 7;
    localparam int OP_W     = 2;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 8;

    // Digit counts of a full 64-bit value
    localparam int HEX_DIGITS = 16;
    localparam int OCT_DIGITS = 22;

    // Conversion codes
    localparam logic [OP_W-1:0] OP_HEX_LO = 2'd0;
    localparam logic [OP_W-1:0] OP_HEX_UP = 2'd1;
    localparam logic [OP_W-1:0] OP_PTR    = 2'd2;
    localparam logic [OP_W-1:0] OP_OCT    = 2'd3;

    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_X_LO  = 8'h78;
    localparam logic [7:0] ASCII_X_UP  = 8'h58;
    localparam logic [7:0] ASCII_A_LO  = 8'h61;
    localparam logic [7:0] ASCII_A_UP  = 8'h41;

    // Map one digit value to its ASCII character
    function automatic logic [7:0] ascii_digit(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? ASCII_A_UP : ASCII_A_LO;
        if (d < 4'd10) begin
            ascii_digit = ASCII_ZERO + {4'd0, d};
        end else begin
            ascii_digit = base + {4'd0, d} - 8'd10;
        end
    endfunction

endpackage

// ===== sv/hex_octal_field_formatter_unit.sv =====
// Top level of the hex/octal field formatter: scan, fill count and character emitter.
//
// Usage:
//   Slave side (i_s_*) takes one request per field: the value, the conversion
//   code on tuser and the format flags and width in tdata. Master side (o_m_*)
//   returns the field as ASCII characters, one per beat, with o_m_tlast on the
//   final character of the field.
//   A request is taken only while the unit is idle. After acceptance the value
//   sits in a 66-bit shift register that moves one hex or octal digit per
//   cycle while not stalled: the scan drops leading zero digits one per cycle
//   (up to 15 digits for hex, 21 for octal), then sizes prefix and fill.
//   Emission then produces one character per cycle into an output register
//   while the receiver takes each character; the first character reaches the
//   master side from that register once the unit has entered the emit state.
//   When the receiver stalls, the output register holds its character and
//   emission pauses; the next request may be accepted while the final
//   character still waits in the output register.
//   Reset (synchronous, active low) returns the unit to idle and drops any
//   character held in the output register.
module hex_octal_field_formatter_unit #(
    parameter int MAX_WIDTH = hoff_pkg::MAX_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Slave side
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata: value[63:0], alt_form[64], zero_pad[65], left_justify[66],
    //        field_width[73:67], zero[79:74]
    input  logic [hoff_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // tuser: opcode[1:0]
    input  logic [hoff_pkg::OP_W-1:0]        i_s_tuser,
    // Master side
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata: ch[7:0]
    output logic [hoff_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic                             o_m_tlast
);
    import hoff_pkg::*;

`include "assert_macros.svh"

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = (CW > FWIDTH_W) ? CW : FWIDTH_W;
    localparam int SR_W = VALUE_W + 2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [SR_W-1:0]     r_sr, n_sr;
    logic [4:0]          r_nd, n_nd;
    logic [1:0]          r_np, n_np;
    logic [CW-1:0]       r_fill, n_fill;
    logic [CW-1:0]       r_left, n_left;
    logic                r_octal, r_upper, r_zp, r_lj;
    logic [FWIDTH_W-1:0] r_width;
    logic                r_m_valid, n_m_valid;
    logic [7:0]          r_m_data, n_m_data;
    logic                r_m_last, n_m_last;

    logic                w_accept;
    logic                w_emit;
    logic [3:0]          w_top_dig;
    logic [AW-1:0]       w_wc, w_sum;
    logic [VALUE_W-1:0]  w_value;
    logic [OP_W-1:0]     w_op;
    logic                w_alt;
    logic [AW-1:0]       w_seg_sum;

    assign w_value = i_s_tdata[VALUE_W-1:0];
    assign w_op    = i_s_tuser;
    assign w_alt   = i_s_tdata[VALUE_W];

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_emit     = (r_state == ST_EMIT) && (!r_m_valid || i_m_tready);

    assign w_top_dig = r_octal ? {1'b0, r_sr[SR_W-1 -: 3]} : r_sr[SR_W-1 -: 4];

    // Clamp width, then size the field from digits and prefix
    assign w_wc  = (AW'(r_width) > AW'(MAX_WIDTH)) ? AW'(MAX_WIDTH) : AW'(r_width);
    assign w_sum = AW'(r_nd) + AW'(r_np);
    assign w_seg_sum = AW'(r_fill) + AW'(r_np) + AW'(r_nd);

    always_comb begin
        n_state   = r_state;
        n_sr      = r_sr;
        n_nd      = r_nd;
        n_np      = r_np;
        n_fill    = r_fill;
        n_left    = r_left;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        n_m_last  = r_m_last;

        // Drop the held character once the receiver takes it
        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_op == OP_OCT) begin
                        n_sr = {2'b00, w_value};
                        n_nd = 5'(OCT_DIGITS);
                        n_np = ((|w_value) && w_alt) ? 2'd1 : 2'd0;
                    end else begin
                        n_sr = {w_value, 2'b00};
                        n_nd = 5'(HEX_DIGITS);
                        n_np = ((|w_value) && (w_alt || w_op == OP_PTR)) ? 2'd2 : 2'd0;
                    end
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Skip one leading zero digit per cycle, keep at least one
                if (r_nd > 5'd1 && w_top_dig == 4'd0) begin
                    n_sr = r_octal ? (r_sr << 3) : (r_sr << 4);
                    n_nd = r_nd - 5'd1;
                end else begin
                    n_fill  = (w_wc > w_sum) ? CW'(w_wc - w_sum) : '0;
                    n_left  = (w_wc > w_sum) ? CW'(w_wc) : CW'(w_sum);
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_emit) begin
                    n_m_valid = 1'b1;
                    n_m_last  = (r_left == CW'(1));
                    n_left    = r_left - CW'(1);
                    if (!r_zp && !r_lj && r_fill != '0) begin
                        n_m_data = ASCII_SPACE;
                        n_fill   = r_fill - CW'(1);
                    end else if (r_np != 2'd0) begin
                        if (r_np == 2'd2 || r_octal) begin
                            n_m_data = ASCII_ZERO;
                        end else begin
                            n_m_data = r_upper ? ASCII_X_UP : ASCII_X_LO;
                        end
                        n_np = r_np - 2'd1;
                    end else if (r_zp && !r_lj && r_fill != '0) begin
                        n_m_data = ASCII_ZERO;
                        n_fill   = r_fill - CW'(1);
                    end else if (r_nd != 5'd0) begin
                        n_m_data = ascii_digit(w_top_dig, r_upper);
                        n_sr     = r_octal ? (r_sr << 3) : (r_sr << 4);
                        n_nd     = r_nd - 5'd1;
                    end else begin
                        n_m_data = r_zp ? ASCII_ZERO : ASCII_SPACE;
                        n_fill   = r_fill - CW'(1);
                    end
                    if (r_left == CW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_sr     <= n_sr;
        r_nd     <= n_nd;
        r_np     <= n_np;
        r_fill   <= n_fill;
        r_left   <= n_left;
        r_m_data <= n_m_data;
        r_m_last <= n_m_last;
        if (w_accept) begin
            r_octal <= (w_op == OP_OCT);
            r_upper <= (w_op == OP_HEX_UP);
            r_zp    <= i_s_tdata[VALUE_W+1];
            r_lj    <= i_s_tdata[VALUE_W+2];
            r_width <= i_s_tdata[VALUE_W+3 +: FWIDTH_W];
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;

    // The character count matches what the segments still hold
    `HOFF_ASSERT_IMPL(a_last_segments_done, w_emit && r_left == CW'(1), w_seg_sum == AW'(1))
    // Final character returns the unit to idle
    `HOFF_ASSERT_NEXT(a_last_goes_idle, w_emit && r_left == CW'(1), r_state == ST_IDLE)
    // The scan always keeps at least one digit
    `HOFF_ASSERT_IMPL(a_scan_keeps_digit, r_state == ST_SCAN, r_nd != 5'd0)

endmodule

// ===== tb/sv/hex_octal_field_formatter_unit_tb.sv =====
// Self-checking testbench for the hex/octal field formatter: directed table, then random requests.
`timescale 1ns / 100ps

module hex_octal_field_formatter_unit_tb;
    import hoff_pkg::*;

    localparam int MAX_FIELD    = MAX_WIDTH_DEF;
    localparam int N_DIRECTED   = 22;
    localparam int RANDOM_ITEMS = 288;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 120;

    // One formatting request as the slave side carries it
    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  op;
        logic        alt;
        logic        zpad;
        logic        ljust;
        logic [6:0]  width;
    } t_fmt_req;

    // One character of a formatted field
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_fmt_char;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    // tdata: value[63:0], alt_form[64], zero_pad[65], left_justify[66],
    //        field_width[73:67], zero[79:74]
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    // tuser: opcode[1:0]
    logic [OP_W-1:0]       i_s_tuser = OP_HEX_LO;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // tdata: ch[7:0]
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic        o_m_tlast;

    t_fmt_char field_chars_due [$];
    t_fmt_char oldest_char;
    int        fail_count  = 0;
    int        quiet_cycles = 0;
    bit        steady      = 1'b0;

    // Directed rows; a nonempty text is the field typed in, else the predictor decides
    localparam t_fmt_req DIRECTED [N_DIRECTED] = '{
        '{64'd0,                  OP_HEX_LO, 1'b0, 1'b0, 1'b0, 7'd0},
        '{64'd0,                  OP_PTR,    1'b1, 1'b1, 1'b0, 7'd0},
        '{64'hFFFF_FFFF_FFFF_FFFF, OP_HEX_LO, 1'b1, 1'b0, 1'b0, 7'd0},
        '{64'hFFFF_FFFF_FFFF_FFFF, OP_HEX_UP, 1'b1, 1'b0, 1'b0, 7'd0},
        '{64'hFFFF_FFFF_FFFF_FFFF, OP_OCT,    1'b1, 1'b0, 1'b0, 7'd0},
        '{64'hFFFF_FFFF_FFFF_FFFF, OP_OCT,    1'b0, 1'b0, 1'b0, 7'd0},
        '{64'hFF,                 OP_HEX_LO, 1'b1, 1'b1, 1'b0, 7'd8},
        '{64'hFF,                 OP_HEX_LO, 1'b1, 1'b0, 1'b1, 7'd8},
        '{64'hFF,                 OP_HEX_LO, 1'b0, 1'b0, 1'b0, 7'd5},
        '{64'h0123_4567_89AB_CDEF, OP_HEX_UP, 1'b1, 1'b1, 1'b1, 7'd20},
        '{64'd1,                  OP_PTR,    1'b0, 1'b0, 1'b0, 7'd0},
        '{64'd8,                  OP_OCT,    1'b1, 1'b0, 1'b0, 7'd0},
        '{64'h8000_0000_0000_0000, OP_OCT,    1'b0, 1'b0, 1'b0, 7'd64},
        '{64'd0,                  OP_OCT,    1'b1, 1'b1, 1'b0, 7'd64},
        '{64'hDEAD_BEEF,          OP_PTR,    1'b0, 1'b1, 1'b1, 7'd127},
        '{64'h5,                  OP_HEX_LO, 1'b1, 1'b1, 1'b1, 7'd65},
        '{64'hFEDC_BA98_7654_3210, OP_PTR,    1'b1, 1'b0, 1'b0, 7'd64},
        '{64'd7,                  OP_OCT,    1'b0, 1'b1, 1'b0, 7'd3},
        '{64'hABC,                OP_HEX_UP, 1'b1, 1'b0, 1'b0, 7'd2},
        '{64'd1,                  OP_HEX_LO, 1'b0, 1'b0, 1'b0, 7'd1},
        '{64'hFFFF_FFFF_FFFF_FFFF, OP_HEX_LO, 1'b0, 1'b1, 1'b0, 7'd127},
        '{64'd0,                  OP_HEX_UP, 1'b1, 1'b0, 1'b1, 7'd3}
    };

    string typed_field [N_DIRECTED] = '{
        "0",
        "0",
        "0xffffffffffffffff",
        "0XFFFFFFFFFFFFFFFF",
        "",
        "",
        "0x0000ff",
        "0xff    ",
        "   ff",
        "",
        "0x1",
        "010",
        "",
        "",
        "",
        "",
        "",
        "007",
        "0XABC",
        "1",
        "",
        "0  "
    };

    hex_octal_field_formatter_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always #6 i_clk = ~i_clk;

    // Format one request and queue its characters, last marker on the final one
    task automatic format_field(input t_fmt_req r);
        logic [7:0]  digit_buf [0:23];
        logic [7:0]  pre_buf [0:1];
        logic [7:0]  field_buf [0:MAX_FIELD+23];
        logic [7:0]  nib;
        logic [7:0]  fill_ch;
        logic [63:0] rest;
        bit          octal;
        bit          upper;
        int          n_dig;
        int          n_pre;
        int          n_fill;
        int          n_tot;
        int          lim;
        int          i;
        t_fmt_char   c;
        octal   = (r.op == OP_OCT);
        upper   = (r.op == OP_HEX_UP);
        lim     = (int'(r.width) > MAX_FIELD) ? MAX_FIELD : int'(r.width);
        fill_ch = r.zpad ? ASCII_ZERO : ASCII_SPACE;

        // Collect digits, least significant first; zero still yields one digit
        rest  = r.value;
        n_dig = 0;
        do begin
            nib = octal ? {5'd0, rest[2:0]} : {4'd0, rest[3:0]};
            digit_buf[n_dig] = (nib < 8'd10) ? ASCII_ZERO + nib
                                             : (upper ? ASCII_A_UP : ASCII_A_LO) + nib - 8'd10;
            rest = octal ? (rest >> 3) : (rest >> 4);
            n_dig++;
        end while (rest != 64'd0);

        // Radix prefix only for a nonzero value
        n_pre = 0;
        if (r.value != 64'd0) begin
            if (octal) begin
                if (r.alt) begin
                    pre_buf[0] = ASCII_ZERO;
                    n_pre = 1;
                end
            end else if (r.alt || r.op == OP_PTR) begin
                pre_buf[0] = ASCII_ZERO;
                pre_buf[1] = upper ? ASCII_X_UP : ASCII_X_LO;
                n_pre = 2;
            end
        end

        n_fill = (lim > n_dig + n_pre) ? lim - n_dig - n_pre : 0;

        n_tot = 0;
        if (!r.zpad && !r.ljust) begin
            for (i = 0; i < n_fill; i++) begin
                field_buf[n_tot] = fill_ch;
                n_tot++;
            end
        end
        for (i = 0; i < n_pre; i++) begin
            field_buf[n_tot] = pre_buf[i];
            n_tot++;
        end
        if (r.zpad && !r.ljust) begin
            for (i = 0; i < n_fill; i++) begin
                field_buf[n_tot] = fill_ch;
                n_tot++;
            end
        end
        for (i = n_dig; i > 0; i--) begin
            field_buf[n_tot] = digit_buf[i-1];
            n_tot++;
        end
        if (r.ljust) begin
            for (i = 0; i < n_fill; i++) begin
                field_buf[n_tot] = fill_ch;
                n_tot++;
            end
        end

        for (i = 0; i < n_tot; i++) begin
            c.ch   = field_buf[i];
            c.last = (i == n_tot - 1);
            field_chars_due.push_back(c);
        end
    endtask

    // Offer one request, hold it until taken, then queue what it must produce
    task automatic send_request(input t_fmt_req r, input string typed);
        t_fmt_char c;
        int        j;
        if (!steady) begin
            while ($urandom_range(0, 99) < 9) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'd0, r.width, r.ljust, r.zpad, r.alt, r.value};
        i_s_tuser  <= r.op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);

        if (typed.len() > 0) begin
            for (j = 0; j < typed.len(); j++) begin
                c.ch   = typed[j];
                c.last = (j == typed.len() - 1);
                field_chars_due.push_back(c);
            end
        end else begin
            format_field(r);
        end
    endtask

    // Stall the receiver now and then, except inside the steady stretch
    always @(posedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(0, 99) >= 9);
    end

    // Compare every accepted character with the oldest one due
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (field_chars_due.size() == 0) begin
                $error("unexpected character: ch=%h last=%b", o_m_tdata, o_m_tlast);
                fail_count++;
            end else begin
                oldest_char = field_chars_due.pop_front();
                if (o_m_tdata !== oldest_char.ch) begin
                    $error("ch mismatch: expected %h, actual %h", oldest_char.ch, o_m_tdata);
                    fail_count++;
                end
                if (o_m_tlast !== oldest_char.last) begin
                    $error("last mismatch: expected %b, actual %b", oldest_char.last, o_m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Count cycles in which neither side moves a request or a character
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("hex_octal_field_formatter_unit test failed");
        $finish;
    end

    initial begin
        t_fmt_req req;
        int       k;
        int       mode;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < N_DIRECTED; k++) begin
            send_request(DIRECTED[k], typed_field[k]);
        end

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            // Drop all idling on both sides for a long stretch in the middle
            steady = (k >= 120 && k < 200);
            mode = $urandom_range(0, 9);
            case (mode)
                0: begin
                    req.value = 64'd0;
                end
                1: begin
                    req.value = 64'hFFFF_FFFF_FFFF_FFFF;
                end
                2: begin
                    req.value = 64'd1 << $urandom_range(0, 63);
                end
                default: begin
                    req.value = {$urandom, $urandom} >> $urandom_range(0, 63);
                end
            endcase
            req.op    = 2'($urandom_range(0, 3));
            req.alt   = 1'($urandom_range(0, 1));
            req.zpad  = 1'($urandom_range(0, 1));
            req.ljust = 1'($urandom_range(0, 1));
            // Keep most fields short; reach past the maximum width now and then
            req.width = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                    : 7'($urandom_range(0, 28));
            send_request(req, "");
        end
        steady = 1'b0;
        i_s_tvalid <= 1'b0;

        while (field_chars_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("hex_octal_field_formatter_unit test passed");
        end else begin
            $display("hex_octal_field_formatter_unit test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/hoff_pkg.sv
sv/hex_octal_field_formatter_unit.sv
tb/sv/hex_octal_field_formatter_unit_tb.sv
